FILE: design/bbs_pkg.sv
// Package for the ball bounce step unit.
// Holds op codes, config register indexes, multiplier select codes and
// the command and configuration structs. No dependencies.
package bbs_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_HIT   = 2'd1;
    localparam logic [1:0] OP_SERVE = 2'd2;

    localparam logic [2:0] CFG_TIME_SCALE   = 3'd0;
    localparam logic [2:0] CFG_GRAVITY      = 3'd1;
    localparam logic [2:0] CFG_GROUND_REST  = 3'd2;
    localparam logic [2:0] CFG_WALL_REST    = 3'd3;
    localparam logic [2:0] CFG_NET_REST     = 3'd4;
    localparam logic [2:0] CFG_HALF_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_CEILING      = 3'd6;
    localparam logic [2:0] CFG_NET_HEIGHT   = 3'd7;

    // multiplier operand selects
    localparam logic [2:0] MS_DT = 3'd0;
    localparam logic [2:0] MS_VX = 3'd1;
    localparam logic [2:0] MS_VY = 3'd2;
    localparam logic [2:0] MS_G  = 3'd3;
    localparam logic [2:0] MS_BY = 3'd4;
    localparam logic [2:0] MS_BX = 3'd5;
    localparam logic [2:0] MS_BN = 3'd6;

    typedef struct packed {
        logic [15:0]        time_scale;
        logic signed [15:0] gravity;
        logic [7:0]         ground_rest;
        logic [7:0]         wall_rest;
        logic [7:0]         net_rest;
        logic [14:0]        half_width;
        logic [14:0]        ceiling_height;
        logic [14:0]        net_height;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       apply;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       dt_load;
        logic       upd_px;
        logic       upd_py;
        logic       upd_vy;
        logic       clamp;
        logic       bnc_y;
        logic       bnc_x;
        logic       net_chk;
        logic       bnc_n;
        logic       out_load;
    } t_cmd;

endpackage

FILE: design/bbs_ifs.sv
// Valid/ready channel interfaces of the ball bounce step unit.
// bbs_in_if carries one item in, bbs_out_if one result item out. No dependencies.
interface bbs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [15:0]        delta_time;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic               serve_player;
    logic signed [15:0] player_pos_x;

    modport source (output valid, op, delta_time, new_vel_x, new_vel_y, serve_player,
                    player_pos_x, input ready);
    modport sink   (input valid, op, delta_time, new_vel_x, new_vel_y, serve_player,
                    player_pos_x, output ready);
endinterface

interface bbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ball_x;
    logic signed [15:0] ball_y;
    logic               ball_side;
    logic               hit_ground;
    logic               hit_wall;
    logic               hit_net;
    logic               side_changed;
    logic               hit_racket;

    modport source (output valid, ball_x, ball_y, ball_side, hit_ground, hit_wall, hit_net,
                    side_changed, hit_racket, input ready);
    modport sink   (input valid, ball_x, ball_y, ball_side, hit_ground, hit_wall, hit_net,
                    side_changed, hit_racket, output ready);
endinterface

FILE: design/bbs_cfg.sv
// Configuration register file of the ball bounce step unit.
// Depends on bbs_pkg.
module bbs_cfg
    import bbs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [2:0]  i_idx,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    localparam int GRAV_RAW = -(9 * (1 << FRAC_BITS));
    localparam int GRAV_SAT = (GRAV_RAW < -32768) ? -32768 : GRAV_RAW;
    localparam int HW_RAW   = 4 * (1 << FRAC_BITS);
    localparam int CEIL_RAW = 8 * (1 << FRAC_BITS);
    localparam int NET_RAW  = 1 << FRAC_BITS;
    localparam logic signed [15:0] GRAV_RST = 16'(GRAV_SAT);
    localparam logic [14:0] HW_RST   = 15'((HW_RAW > 32767) ? 32767 : HW_RAW);
    localparam logic [14:0] CEIL_RST = 15'((CEIL_RAW > 32767) ? 32767 : CEIL_RAW);
    localparam logic [14:0] NET_RST  = 15'((NET_RAW > 32767) ? 32767 : NET_RAW);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_scale     <= 16'd256;
            r_cfg.gravity        <= GRAV_RST;
            r_cfg.ground_rest    <= 8'd205;
            r_cfg.wall_rest      <= 8'd205;
            r_cfg.net_rest       <= 8'd26;
            r_cfg.half_width     <= HW_RST;
            r_cfg.ceiling_height <= CEIL_RST;
            r_cfg.net_height     <= NET_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_TIME_SCALE:  r_cfg.time_scale     <= i_data;
                CFG_GRAVITY:     r_cfg.gravity        <= i_data;
                CFG_GROUND_REST: r_cfg.ground_rest    <= i_data[7:0];
                CFG_WALL_REST:   r_cfg.wall_rest      <= i_data[7:0];
                CFG_NET_REST:    r_cfg.net_rest       <= i_data[7:0];
                CFG_HALF_WIDTH:  r_cfg.half_width     <= i_data[14:0];
                CFG_CEILING:     r_cfg.ceiling_height <= i_data[14:0];
                CFG_NET_HEIGHT:  r_cfg.net_height     <= i_data[14:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/bbs_ctrl.sv
// Sequencing controller of the ball bounce step unit.
// Drives the datapath command struct and both handshakes. Depends on bbs_pkg.
module bbs_ctrl
    import bbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_APPLY = 4'd1;
    localparam logic [3:0] S_VX    = 4'd2;
    localparam logic [3:0] S_VY    = 4'd3;
    localparam logic [3:0] S_G     = 4'd4;
    localparam logic [3:0] S_CLAMP = 4'd5;
    localparam logic [3:0] S_BY    = 4'd6;
    localparam logic [3:0] S_BX    = 4'd7;
    localparam logic [3:0] S_WX    = 4'd8;
    localparam logic [3:0] S_BN    = 4'd9;
    localparam logic [3:0] S_NX    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MS_DT;
                    n_state     = (i_in_op == OP_TICK) ? S_VX : S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                n_state   = S_FIN;
            end
            S_VX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_VX;
                cmd.dt_load = 1'b1;
                n_state     = S_VY;
            end
            S_VY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_VY;
                cmd.upd_px  = 1'b1;
                n_state     = S_G;
            end
            S_G: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_G;
                cmd.upd_py  = 1'b1;
                n_state     = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.upd_vy = 1'b1;
                cmd.clamp  = 1'b1;
                n_state    = S_BY;
            end
            S_BY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BY;
                n_state     = S_BX;
            end
            S_BX: begin
                cmd.bnc_y   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BX;
                cmd.net_chk = 1'b1;
                n_state     = S_WX;
            end
            S_WX: begin
                cmd.bnc_x = 1'b1;
                n_state   = S_BN;
            end
            S_BN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_BN;
                n_state     = S_NX;
            end
            S_NX: begin
                cmd.bnc_n = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: design/bbs_dp.sv
// Datapath of the ball bounce step unit: ball state, shared multiplier,
// rounding, saturation, bounce and net logic, output register. Depends on bbs_pkg.
module bbs_dp
    import bbs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_delta_time,
    input  logic signed [15:0] i_new_vel_x,
    input  logic signed [15:0] i_new_vel_y,
    input  logic               i_serve_player,
    input  logic signed [15:0] i_player_pos_x,
    output logic signed [15:0] o_ball_x,
    output logic signed [15:0] o_ball_y,
    output logic               o_ball_side,
    output logic               o_hit_ground,
    output logic               o_hit_wall,
    output logic               o_hit_net,
    output logic               o_side_changed,
    output logic               o_hit_racket
);

    localparam int SERVE_OFF_I = ((2 << FRAC_BITS) + 5) / 10;
    localparam int SERVE_Y_I   = 5 << (FRAC_BITS - 1);
    localparam int SERVE_VY_I  = 5 << FRAC_BITS;
    localparam logic signed [16:0] SERVE_OFF = 17'(SERVE_OFF_I);
    localparam logic signed [15:0] SERVE_Y   = 16'((SERVE_Y_I > 32767) ? 32767 : SERVE_Y_I);
    localparam logic signed [15:0] SERVE_VY  = 16'((SERVE_VY_I > 32767) ? 32767 : SERVE_VY_I);
    localparam logic signed [47:0] STEP_HALF = 48'sd8388608;

    function automatic logic signed [15:0] f_sat16(input logic signed [25:0] v);
        logic signed [15:0] res;
        if (v > 26'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // ball state
    logic signed [15:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic               r_side;
    // flags of the current item
    logic r_g, r_w, r_n, r_sc, r_r, r_by_en;
    // working registers
    logic               r_by_g;
    logic signed [47:0] r_prod;
    logic [31:0]        r_dt;
    logic [1:0]         r_op;
    logic signed [15:0] r_new_vx, r_new_vy, r_player_pos_x;
    logic               r_serve_player;
    // output register
    logic signed [15:0] r_out_x, r_out_y;
    logic r_out_side, r_out_g, r_out_w, r_out_n, r_out_sc, r_out_r;

    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] mul_p;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DT: begin
                mul_a = {1'b0, i_delta_time};
                mul_b = {17'd0, i_cfg.time_scale};
            end
            MS_VX: begin
                mul_a = 17'(r_vel_x);
                mul_b = {1'b0, r_prod[31:0]};
            end
            MS_VY: begin
                mul_a = 17'(r_vel_y);
                mul_b = {1'b0, r_dt};
            end
            MS_G: begin
                mul_a = 17'(i_cfg.gravity);
                mul_b = {1'b0, r_dt};
            end
            MS_BY: begin
                mul_a = 17'(r_vel_y);
                mul_b = {25'd0, (r_by_g ? i_cfg.ground_rest : i_cfg.wall_rest)};
            end
            MS_BX: begin
                mul_a = 17'(r_vel_x);
                mul_b = {25'd0, i_cfg.wall_rest};
            end
            MS_BN: begin
                mul_a = 17'(r_vel_x);
                mul_b = {25'd0, i_cfg.net_rest};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // step term: round half up of product / 2^24
    logic signed [47:0] step_sum;
    logic signed [23:0] step_q;
    logic signed [15:0] step_pos_x, step_pos_y, step_vel_y;
    assign step_sum   = r_prod + STEP_HALF;
    assign step_q     = step_sum[47:24];
    assign step_pos_x = f_sat16(26'(r_pos_x) + 26'(step_q));
    assign step_pos_y = f_sat16(26'(r_pos_y) + 26'(step_q));
    assign step_vel_y = f_sat16(26'(r_vel_y) + 26'(step_q));

    // bounce: -(v * r) / 2^8, round half up
    logic signed [25:0] bnc_p, bnc_neg;
    logic signed [17:0] bnc_q;
    logic signed [15:0] bnc_v;
    assign bnc_p   = r_prod[25:0];
    assign bnc_neg = 26'sd128 - bnc_p;
    assign bnc_q   = bnc_neg[25:8];
    assign bnc_v   = f_sat16(26'(bnc_q));

    logic signed [15:0] hw_s, neg_hw, ceil_s, net_s;
    assign hw_s   = {1'b0, i_cfg.half_width};
    assign neg_hw = -hw_s;
    assign ceil_s = {1'b0, i_cfg.ceiling_height};
    assign net_s  = {1'b0, i_cfg.net_height};

    logic signed [16:0] srv_px, srv_sum;
    logic signed [15:0] srv_x;
    assign srv_px  = 17'(r_player_pos_x);
    assign srv_sum = r_player_pos_x[15] ? (srv_px - SERVE_OFF) : (srv_px + SERVE_OFF);
    assign srv_x   = f_sat16(26'(srv_sum));

    logic nside;
    assign nside = ~r_pos_x[15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_side  <= 1'b0;
            r_g     <= 1'b0;
            r_w     <= 1'b0;
            r_n     <= 1'b0;
            r_sc    <= 1'b0;
            r_r     <= 1'b0;
            r_by_en <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_g     <= 1'b0;
                r_w     <= 1'b0;
                r_n     <= 1'b0;
                r_sc    <= 1'b0;
                r_r     <= 1'b0;
                r_by_en <= 1'b0;
            end
            if (i_cmd.apply) begin
                unique case (r_op)
                    OP_HIT: begin
                        r_vel_x <= r_new_vx;
                        r_vel_y <= r_new_vy;
                        r_r     <= 1'b1;
                    end
                    OP_SERVE: begin
                        r_pos_x <= srv_x;
                        r_pos_y <= SERVE_Y;
                        r_side  <= r_serve_player;
                        r_vel_x <= '0;
                        r_vel_y <= SERVE_VY;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.upd_px) begin
                r_pos_x <= step_pos_x;
            end
            if (i_cmd.upd_py) begin
                r_pos_y <= step_pos_y;
            end
            if (i_cmd.upd_vy) begin
                r_vel_y <= step_vel_y;
            end
            if (i_cmd.clamp) begin
                if (r_pos_y < 16'sd0) begin
                    r_pos_y <= '0;
                    r_g     <= 1'b1;
                    r_by_en <= 1'b1;
                end else if (r_pos_y > ceil_s) begin
                    r_pos_y <= ceil_s;
                    r_by_en <= 1'b1;
                end
                if (r_pos_x > hw_s) begin
                    r_pos_x <= hw_s;
                    r_w     <= 1'b1;
                end else if (r_pos_x < neg_hw) begin
                    r_pos_x <= neg_hw;
                    r_w     <= 1'b1;
                end
            end
            if (i_cmd.bnc_y && r_by_en) begin
                r_vel_y <= bnc_v;
            end
            if (i_cmd.net_chk && (nside != r_side)) begin
                if (r_pos_y < net_s) begin
                    r_n <= 1'b1;
                end else begin
                    r_sc   <= 1'b1;
                    r_side <= nside;
                end
            end
            if (i_cmd.bnc_x && r_w) begin
                r_vel_x <= bnc_v;
            end
            if (i_cmd.bnc_n && r_n) begin
                r_vel_x <= bnc_v;
                r_pos_x <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op           <= i_op;
            r_new_vx       <= i_new_vel_x;
            r_new_vy       <= i_new_vel_y;
            r_serve_player <= i_serve_player;
            r_player_pos_x <= i_player_pos_x;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[47:0];
        end
        if (i_cmd.dt_load) begin
            r_dt <= r_prod[31:0];
        end
        if (i_cmd.clamp) begin
            r_by_g <= (r_pos_y < 16'sd0);
        end
        if (i_cmd.out_load) begin
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_side <= r_side;
            r_out_g    <= r_g;
            r_out_w    <= r_w;
            r_out_n    <= r_n;
            r_out_sc   <= r_sc;
            r_out_r    <= r_r;
        end
    end

    assign o_ball_x       = r_out_x;
    assign o_ball_y       = r_out_y;
    assign o_ball_side    = r_out_side;
    assign o_hit_ground   = r_out_g;
    assign o_hit_wall     = r_out_w;
    assign o_hit_net      = r_out_n;
    assign o_side_changed = r_out_sc;
    assign o_hit_racket   = r_out_r;

endmodule

FILE: design/ball_bounce_step_unit.sv
// Top level of the ball bounce step unit.
// Depends on bbs_pkg, bbs_ifs, bbs_cfg, bbs_ctrl and bbs_dp.
//
// Usage:
//  Items enter on i_in (valid/ready); op selects tick, racket hit or serve.
//  Each item yields exactly one result item on o_out (valid/ready): the ball
//  position and side after the item plus ground, wall, net, side change and
//  racket flags.
//  Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data,
//  one register per cycle; the user must write them only while no item is in
//  flight, since the block itself does not enforce this.
//  Timing: one item at a time. A tick walks a ten step sequence through one
//  shared 17x33 multiplier (scaled time, three Euler products, ground or
//  ceiling bounce, wall bounce, net bounce) before its result is loaded. Hit,
//  serve and the unused op pass through a single apply step instead.
//  The result sits in an output register; the next item is accepted while it
//  waits, and that item's result is held back until the old one is taken.
//  Reset (synchronous, active low) zeroes position, velocity and side, loads
//  the default register values and empties the output register.
module ball_bounce_step_unit
    import bbs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    bbs_in_if.sink      i_in,
    bbs_out_if.source   o_out
);

    t_cfg cfg;
    t_cmd cmd;

    bbs_cfg #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    bbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_out_ready(o_out.ready),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .o_cmd      (cmd)
    );

    bbs_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_op          (i_in.op),
        .i_delta_time  (i_in.delta_time),
        .i_new_vel_x   (i_in.new_vel_x),
        .i_new_vel_y   (i_in.new_vel_y),
        .i_serve_player(i_in.serve_player),
        .i_player_pos_x(i_in.player_pos_x),
        .o_ball_x      (o_out.ball_x),
        .o_ball_y      (o_out.ball_y),
        .o_ball_side   (o_out.ball_side),
        .o_hit_ground  (o_out.hit_ground),
        .o_hit_wall    (o_out.hit_wall),
        .o_hit_net     (o_out.hit_net),
        .o_side_changed(o_out.side_changed),
        .o_hit_racket  (o_out.hit_racket)
    );

endmodule

FILE: design/bbs_checker.sv
// Port level checks for the ball bounce step unit, bound to the top level.
// Depends on ball_bounce_step_unit and its channel interfaces.
module bbs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_hit_ground,
    input logic i_hit_wall,
    input logic i_hit_net,
    input logic i_side_changed,
    input logic i_hit_racket
);

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_racket_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit_racket |->
            !(i_hit_ground || i_hit_wall || i_hit_net || i_side_changed))
        else $error("racket flag with tick flags");

    a_net_xor_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hit_net && i_side_changed))
        else $error("net hit and side change together");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ball_bounce_step_unit bbs_checker u_bbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_hit_ground  (o_out.hit_ground),
    .i_hit_wall    (o_out.hit_wall),
    .i_hit_net     (o_out.hit_net),
    .i_side_changed(o_out.side_changed),
    .i_hit_racket  (o_out.hit_racket)
);
